// ----- sv/pmgr_pkg.sv -----
// ----------------------------------------------------------------------------
// pmgr_pkg
// Types, constants and helper functions of the packet-mode group reassembler.
// ----------------------------------------------------------------------------
package pmgr_pkg;

	localparam int GROUP_BYTES_DEF  = 4096;
	localparam int MAX_PACKET_BYTES = 96;
	localparam int PKT_UNIT         = 24;
	localparam int PAY_IW           = $clog2(MAX_PACKET_BYTES);
	localparam int PAY_ROWS         = (MAX_PACKET_BYTES + 3) / 4;
	localparam int PRW              = $clog2(PAY_ROWS);
	localparam int PAY_DEPTH        = 2 * (1 << PRW);

	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_PRESET = 16'hFFFF;

	localparam logic [2:0] ST_BUSY     = 3'd0;
	localparam logic [2:0] ST_FRAGMENT = 3'd1;
	localparam logic [2:0] ST_CRC_FAIL = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_DONE     = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;
	localparam logic [2:0] ST_IGNORED  = 3'd6;
	localparam logic [2:0] ST_READ     = 3'd7;

	localparam logic [1:0] FL_INTER  = 2'd0;
	localparam logic [1:0] FL_LAST   = 2'd1;
	localparam logic [1:0] FL_FIRST  = 2'd2;
	localparam logic [1:0] FL_SINGLE = 2'd3;

	typedef struct packed {
		logic        func;
		logic [7:0]  data_byte;
		logic        frame_start;
		logic [11:0] read_index;
	} pmgr_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [12:0] group_length;
		logic [7:0]  read_byte;
		logic [9:0]  packet_address;
	} pmgr_out_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [PAY_IW-1:0] packet_len(input logic [1:0] sz);
		logic [PAY_IW-1:0] len;
		unique case (sz)
			2'd0: len = PAY_IW'(PKT_UNIT);
			2'd1: len = PAY_IW'(2 * PKT_UNIT);
			2'd2: len = PAY_IW'(3 * PKT_UNIT);
			default: len = PAY_IW'(4 * PKT_UNIT);
		endcase
		return len;
	endfunction

endpackage

// ----- sv/pmgr_ram.sv -----
// ----------------------------------------------------------------------------
// pmgr_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module pmgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/packet_mode_group_reassembler.sv -----
// ----------------------------------------------------------------------------
// packet_mode_group_reassembler
// Cuts packet-mode bytes into packets, checks each packet CRC and assembles
// data groups in a four-bank byte store that is read back by index.
// ----------------------------------------------------------------------------
// A result is registered in res_s1 and then in out_q before it is offered.
// Throughput: one item per cycle while the output is not stalled. A finished
// packet is copied from the payload buffer into the group store four bytes a
// cycle; a read, or a byte that would finish another packet, waits until
// that copy is done. Reset: control state is cleared at once; the group store
// is undefined until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module packet_mode_group_reassembler
	import pmgr_pkg::*;
#(
	parameter int GROUP_BYTES = GROUP_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  pmgr_in_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output pmgr_out_t rsp
);

	localparam int CW  = $clog2(GROUP_BYTES + 1);
	localparam int GD  = (GROUP_BYTES + 3) / 4;
	localparam int GRW = $clog2(GD);
	localparam int GAW = GRW + 2;

	logic [6:0]        bpos_q;
	logic [1:0]        sz_q;
	logic [23:0]       hdr_q;
	logic [15:0]       crc_q;
	logic [15:0]       rcv_q;
	logic [CW-1:0]     count_q;
	logic              asm_q;
	logic              half_q;

	logic              cp_rd_q;
	logic [PRW-1:0]    cp_row_q;
	logic              cp_half_q;
	logic [PAY_IW-1:0] cp_len_q;
	logic [CW-1:0]     cp_base_q;
	logic              cp_wr_s1;
	logic [PAY_IW-1:0] cp_idx_s1;
	logic              cp_busy;

	logic              valid_s1;
	pmgr_out_t         res_s1;
	logic              rd_s1;
	logic [1:0]        bank_s1;
	logic              s1_adv;
	logic              s1_open;
	logic              out_valid_q;
	pmgr_out_t         out_q;

	logic              acc;
	logic [6:0]        pos;
	logic [1:0]        sz;
	logic [PAY_IW-1:0] plen;
	logic              body;
	logic              fin;
	logic [23:0]       hdr_new;
	logic [15:0]       crc_new;
	logic [15:0]       rcv_new;
	logic [2:0]        st;
	logic [CW-1:0]     count_new;
	logic              asm_new;
	logic              cp_start;
	logic [CW-1:0]     cp_base;
	logic              pay_we;
	logic [PAY_IW-1:0] pidx;
	logic [PRW-1:0]    cp_next;
	logic              rd_ok;
	logic [GAW+11:0]   ridx_w;

	logic [7:0]        pay_rdata [4];
	logic [7:0]        g_rdata   [4];

	assign cp_busy   = cp_rd_q || cp_wr_s1;
	assign s1_adv    = valid_s1 && (!out_valid_q || rsp_ready);
	assign s1_open   = !valid_s1 || s1_adv;
	assign req_ready = s1_open && !(cp_busy && (req.func || fin));
	assign acc       = req_valid && req_ready;

	always_comb begin
		logic [1:0]  flag;
		logic [6:0]  udlen;
		logic [15:0] crc_base;
		logic [23:0] hdr_base;
		logic [15:0] rcv_base;
		pos      = req.frame_start ? 7'd0 : bpos_q;
		sz       = (pos == 7'd0) ? req.data_byte[7:6] : sz_q;
		plen     = packet_len(sz);
		crc_base = (pos == 7'd0) ? CRC_PRESET : crc_q;
		hdr_base = (pos == 7'd0) ? 24'd0 : hdr_q;
		rcv_base = (pos == 7'd0) ? 16'd0 : rcv_q;
		hdr_new  = (pos < 7'd3) ? {hdr_base[15:0], req.data_byte} : hdr_base;
		body     = ({1'b0, pos} + 8'd2) < {1'b0, plen};
		fin      = ({1'b0, pos} + 8'd1) >= {1'b0, plen};
		crc_new  = body ? crc_byte(crc_base, req.data_byte) : crc_base;
		rcv_new  = body ? rcv_base : {rcv_base[7:0], req.data_byte};
		pay_we   = body && (pos >= 7'd3);
		pidx     = PAY_IW'(pos - 7'd3);
		flag     = hdr_new[19:18];
		udlen    = hdr_new[6:0];
		st        = ST_BUSY;
		count_new = count_q;
		asm_new   = asm_q;
		cp_start  = 1'b0;
		cp_base   = count_q;
		if (fin) begin
			priority if (~crc_new != rcv_new) begin
				st = ST_CRC_FAIL;
			end else if (udlen == 7'd0) begin
				st = ST_EMPTY;
			end else if (({1'b0, udlen} + 8'd5) > {1'b0, plen}) begin
				st = ST_IGNORED;
			end else if (flag == FL_FIRST) begin
				st        = ST_FRAGMENT;
				count_new = CW'(udlen);
				asm_new   = 1'b1;
				cp_start  = 1'b1;
				cp_base   = '0;
			end else if (flag == FL_SINGLE || !asm_q) begin
				st = ST_IGNORED;
			end else if (((CW+1)'(count_q) + (CW+1)'(udlen)) > (CW+1)'(GROUP_BYTES)) begin
				st      = ST_OVERFLOW;
				asm_new = 1'b0;
			end else begin
				count_new = count_q + CW'(udlen);
				cp_start  = 1'b1;
				if (flag == FL_LAST) begin
					st      = ST_DONE;
					asm_new = 1'b0;
				end else begin
					st = ST_FRAGMENT;
				end
			end
		end
	end

	assign ridx_w  = (GAW+12)'(req.read_index);
	assign rd_ok   = (CW+12)'(req.read_index) < (CW+12)'(GROUP_BYTES);
	assign cp_next = cp_row_q + PRW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q  <= '0;
			sz_q    <= '0;
			hdr_q   <= '0;
			crc_q   <= CRC_PRESET;
			rcv_q   <= '0;
			count_q <= '0;
			asm_q   <= 1'b0;
			half_q  <= 1'b0;
		end else if (acc && !req.func) begin
			bpos_q <= fin ? 7'd0 : pos + 7'd1;
			sz_q   <= sz;
			hdr_q  <= hdr_new;
			crc_q  <= crc_new;
			rcv_q  <= rcv_new;
			if (fin) begin
				count_q <= count_new;
				asm_q   <= asm_new;
				if (cp_start) begin
					half_q <= ~half_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_rd_q   <= 1'b0;
			cp_row_q  <= '0;
			cp_half_q <= 1'b0;
			cp_len_q  <= '0;
			cp_base_q <= '0;
			cp_wr_s1  <= 1'b0;
			cp_idx_s1 <= '0;
		end else begin
			cp_wr_s1  <= cp_rd_q;
			cp_idx_s1 <= PAY_IW'({cp_row_q, 2'b00});
			if (acc && !req.func && cp_start) begin
				cp_rd_q   <= 1'b1;
				cp_row_q  <= '0;
				cp_half_q <= half_q;
				cp_len_q  <= PAY_IW'(hdr_new[6:0]);
				cp_base_q <= cp_base;
			end else if (cp_rd_q) begin
				cp_row_q <= cp_next;
				if ((PAY_IW+1)'({cp_next, 2'b00}) >= {1'b0, cp_len_q}) begin
					cp_rd_q <= 1'b0;
				end
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_bank
		logic              p_we;
		logic [1:0]        k;
		logic [PAY_IW-1:0] bidx;
		logic [CW:0]       wsum;
		logic              g_we;

		assign p_we = acc && !req.func && pay_we && (pidx[1:0] == 2'(g));
		assign k    = 2'(g) - cp_base_q[1:0];
		assign bidx = cp_idx_s1 + PAY_IW'(k);
		assign wsum = (CW+1)'(cp_base_q) + (CW+1)'(bidx);
		assign g_we = cp_wr_s1 && (bidx < cp_len_q);

		pmgr_ram #(
			.WIDTH (8),
			.DEPTH (PAY_DEPTH)
		) u_pay (
			.clk   (clk),
			.we    (p_we),
			.waddr ({half_q, pidx[PRW+1:2]}),
			.wdata (req.data_byte),
			.re    (cp_rd_q),
			.raddr ({cp_half_q, cp_row_q}),
			.rdata (pay_rdata[g])
		);

		pmgr_ram #(
			.WIDTH (8),
			.DEPTH (GD)
		) u_grp (
			.clk   (clk),
			.we    (g_we),
			.waddr (wsum[GAW-1:2]),
			.wdata (pay_rdata[k]),
			.re    (acc && req.func),
			.raddr (ridx_w[GAW-1:2]),
			.rdata (g_rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1   <= req.func && rd_ok;
			bank_s1 <= req.read_index[1:0];
			if (req.func) begin
				res_s1.status         <= ST_READ;
				res_s1.group_length   <= 13'(count_q);
				res_s1.packet_address <= '0;
			end else begin
				res_s1.status         <= st;
				res_s1.group_length   <= 13'(count_new);
				res_s1.packet_address <= fin ? hdr_new[17:8] : 10'd0;
			end
		end
		if (s1_adv) begin
			out_q.status         <= res_s1.status;
			out_q.group_length   <= res_s1.group_length;
			out_q.read_byte      <= rd_s1 ? g_rdata[bank_s1] : 8'd0;
			out_q.packet_address <= res_s1.packet_address;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_read_not_during_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.func) |-> !cp_busy)
		else $error("group store read accepted while a copy is running");

	a_copy_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !req.func && cp_start) |-> !cp_busy)
		else $error("copy started while a copy is running");

	a_write_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		cp_wr_s1 |-> $past(cp_rd_q))
		else $error("copy write without a payload read");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(count_q) <= (CW+1)'(GROUP_BYTES))
		else $error("group count beyond the store size");

endmodule

// ----- bench/packet_mode_group_reassembler_tb.sv -----
// ----------------------------------------------------------------------------
// packet_mode_group_reassembler_tb
// Self-checking bench for the packet-mode group reassembler. A directed table
// covers empty, oversized and single packets, CRC failures, resync, a
// completed group and a group filled to the byte limit then overflowed.
// Random well-formed groups follow, mixed with reads, noise and broken
// packets. Every result is checked against a local predictor while both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module packet_mode_group_reassembler_tb
	import pmgr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GB          = GROUP_BYTES_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RAND_ITEMS  = 650;
	localparam int RAND_PKTS   = 36;
	localparam int DRAIN       = 40;

	typedef enum logic [2:0] {RK_PACKET, RK_READ, RK_CUT, RK_FILL, RK_TOPUP} row_kind_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_STALL} rx_mode_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  size;
		logic [1:0]  flag;
		logic [9:0]  addr;
		int          ulen;
		bit          bad;
		logic [11:0] idx;
		bit          typed;
		logic [2:0]  want;
	} row_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	pmgr_in_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	pmgr_out_t rsp;

	packet_mode_group_reassembler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	logic [7:0]  p_mem [0:GB-1];
	logic [7:0]  p_pay [0:MAX_PACKET_BYTES-1];
	int          p_count = 0;
	bit          p_assembling = 1'b0;
	int          p_pos = 0;
	logic [23:0] p_hdr = '0;
	logic [15:0] p_crc = CRC_PRESET;
	logic [15:0] p_rx = '0;
	int          mem_hi = 0;

	pmgr_out_t pending_results [$];
	int        errors = 0;
	int        results_checked = 0;
	int        items_sent = 0;
	int        pkts_done = 0;
	int        groups_done = 0;
	int        overflows = 0;
	int        reads_done = 0;
	int        cycle_count = 0;
	int        burst_left = 16;
	int        gap_left = 0;
	bit        need_resync = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results pending.", cycle_count,
				pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		int          k;
		c = crc;
		for (k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic logic [2:0] close_packet(input int plen);
		logic [1:0] flg;
		int         ul;
		int         i;
		flg = p_hdr[19:18];
		ul = int'(p_hdr[6:0]);
		if (~p_crc != p_rx) return ST_CRC_FAIL;
		if (ul == 0) return ST_EMPTY;
		if (ul + 5 > plen) return ST_IGNORED;
		if (flg == FL_FIRST) begin
			for (i = 0; i < ul && i < GB; i++) begin
				p_mem[i] = p_pay[i];
			end
			p_count = ul;
			p_assembling = 1'b1;
			if (p_count > mem_hi) mem_hi = p_count;
			return ST_FRAGMENT;
		end
		if (flg == FL_SINGLE || !p_assembling) return ST_IGNORED;
		if (p_count + ul > GB) begin
			p_assembling = 1'b0;
			return ST_OVERFLOW;
		end
		for (i = 0; i < ul; i++) begin
			p_mem[p_count + i] = p_pay[i];
		end
		p_count += ul;
		if (p_count > mem_hi) mem_hi = p_count;
		if (flg == FL_LAST) begin
			p_assembling = 1'b0;
			return ST_DONE;
		end
		return ST_FRAGMENT;
	endfunction

	function automatic pmgr_out_t next_reassembly_result(input pmgr_in_t it);
		pmgr_out_t  r;
		int         pos;
		int         plen;
		logic [1:0] szc;
		r = '0;
		if (it.func) begin
			r.status = ST_READ;
			if (int'(it.read_index) < GB) r.read_byte = p_mem[it.read_index];
		end else begin
			pos = it.frame_start ? 0 : p_pos;
			if (pos == 0) begin
				p_crc = CRC_PRESET;
				p_hdr = '0;
				p_rx = '0;
			end
			if (pos < 3) p_hdr = {p_hdr[15:0], it.data_byte};
			if (pos == 0) szc = it.data_byte[7:6];
			else if (pos == 1) szc = p_hdr[15:14];
			else szc = p_hdr[23:22];
			plen = (int'(szc) + 1) * PKT_UNIT;
			if (pos + 2 < plen) begin
				p_crc = crc16_step(p_crc, it.data_byte);
				if (pos >= 3) p_pay[pos - 3] = it.data_byte;
			end else begin
				p_rx = {p_rx[7:0], it.data_byte};
			end
			if (pos + 1 >= plen) begin
				p_pos = 0;
				r.status = close_packet(plen);
				r.packet_address = p_hdr[17:8];
			end else begin
				p_pos = pos + 1;
				r.status = ST_BUSY;
			end
		end
		r.group_length = 13'(p_count);
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("[%0t] result %0d: %s got %0h expected %0h", $realtime, results_checked,
			what, got, want);
		errors++;
	endtask

	task automatic offer_item(input pmgr_in_t it, input bit typed, input logic [2:0] want);
		pmgr_out_t e;
		if (gap_left > 0) begin
			req_valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		e = next_reassembly_result(it);
		if (typed) e.status = want;
		pending_results.push_back(e);
		items_sent++;
		if (e.status == ST_READ) reads_done++;
		else if (e.status != ST_BUSY) pkts_done++;
		if (e.status == ST_DONE) groups_done++;
		if (e.status == ST_OVERFLOW) overflows++;
		burst_left--;
		if (burst_left <= 0) begin
			if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(100, 250);
			else burst_left = $urandom_range(1, 24);
			gap_left = $urandom_range(1, 6);
		end
	endtask

	task automatic send_read(input logic [11:0] idx, input bit typed);
		pmgr_in_t it;
		it.func = 1'b1;
		it.data_byte = 8'($urandom);
		it.frame_start = 1'($urandom);
		it.read_index = idx;
		offer_item(it, typed, ST_READ);
	endtask

	task automatic send_packet(input logic [1:0] sz, input logic [1:0] flg,
			input logic [9:0] addr, input int ul, input bit bad, input int cut,
			input bit typed, input logic [2:0] want, input bit mix_reads);
		logic [7:0]  pkt [0:MAX_PACKET_BYTES-1];
		logic [15:0] c;
		int          plen;
		int          n;
		int          i;
		pmgr_in_t    it;
		plen = (int'(sz) + 1) * PKT_UNIT;
		pkt[0] = {sz, 2'($urandom), flg, addr[9:8]};
		pkt[1] = addr[7:0];
		pkt[2] = {1'($urandom), 7'(ul)};
		for (i = 3; i < plen - 2; i++) begin
			pkt[i] = 8'($urandom);
		end
		c = CRC_PRESET;
		for (i = 0; i < plen - 2; i++) begin
			c = crc16_step(c, pkt[i]);
		end
		c = ~c;
		pkt[plen - 2] = c[15:8];
		pkt[plen - 1] = c[7:0];
		if (bad) begin
			i = $urandom_range(2, plen - 1);
			pkt[i] = pkt[i] ^ (8'd1 << $urandom_range(0, 7));
		end
		n = (cut > 0) ? cut : plen;
		for (i = 0; i < n; i++) begin
			if (mix_reads && mem_hi > 0 && $urandom_range(0, 99) < 4) begin
				send_read(12'($urandom_range(0, mem_hi - 1)), 1'b0);
			end
			it.func = 1'b0;
			it.data_byte = pkt[i];
			it.frame_start = (i == 0) ? (need_resync | ($urandom_range(0, 3) == 0)) : 1'b0;
			it.read_index = 12'($urandom);
			offer_item(it, typed && (i == plen - 1), want);
			if (i == 0) need_resync = 1'b0;
		end
		if (cut > 0) need_resync = 1'b1;
	endtask

	task automatic rand_packet(input logic [1:0] flg);
		logic [1:0] sz;
		int         plen;
		int         ul;
		int         pick;
		int         cut;
		bit         bad;
		sz = ($urandom_range(0, 9) < 7) ? 2'd0 : 2'($urandom_range(1, 3));
		plen = (int'(sz) + 1) * PKT_UNIT;
		pick = $urandom_range(0, 99);
		if (pick < 5) ul = 0;
		else if (pick < 12) ul = $urandom_range(plen - 4, 127);
		else ul = $urandom_range(1, plen - 5);
		bad = $urandom_range(0, 99) < 8;
		cut = ($urandom_range(0, 99) < 5) ? $urandom_range(1, plen - 1) : 0;
		send_packet(sz, flg, 10'($urandom), ul, bad, cut, 1'b0, ST_BUSY, 1'b1);
	endtask

	function automatic row_t mk_row(input row_kind_t k, input logic [1:0] sz,
			input logic [1:0] flg, input logic [9:0] a, input int ul, input bit bad,
			input logic [11:0] idx, input bit typed, input logic [2:0] want);
		row_t r;
		r.kind = k;
		r.size = sz;
		r.flag = flg;
		r.addr = a;
		r.ulen = ul;
		r.bad = bad;
		r.idx = idx;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       phase;
		pmgr_out_t e;
		rsp_ready <= 1'b0;
		mode = RX_OPEN;
		mode_left = 0;
		phase = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("result with nothing pending", 16'(rsp.status), 16'd0);
				end else begin
					e = pending_results.pop_front();
					if (rsp.status !== e.status)
						flag_mismatch("status", 16'(rsp.status), 16'(e.status));
					if (rsp.group_length !== e.group_length)
						flag_mismatch("group_length", 16'(rsp.group_length),
							16'(e.group_length));
					if (rsp.read_byte !== e.read_byte)
						flag_mismatch("read_byte", 16'(rsp.read_byte), 16'(e.read_byte));
					if (rsp.packet_address !== e.packet_address)
						flag_mismatch("packet_address", 16'(rsp.packet_address),
							16'(e.packet_address));
				end
				results_checked++;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(40, 160);
			end
			mode_left--;
			phase++;
			unique case (mode)
				RX_OPEN: begin
					rsp_ready <= 1'b1;
				end
				RX_COIN: begin
					rsp_ready <= 1'($urandom);
				end
				RX_SPARSE: begin
					rsp_ready <= (phase % 7) < 3;
				end
				default: begin
					rsp_ready <= (phase % 16) >= 12;
				end
			endcase
		end
	end

	initial begin
		row_t plan [$];
		int   k;
		int   rand_items0;
		int   rand_pkts0;
		int   pick;
		int   n;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		plan.push_back(mk_row(RK_PACKET, 2'd0, FL_FIRST, 10'h000, 0, 0, 0, 1, ST_EMPTY));
		plan.push_back(mk_row(RK_PACKET, 2'd0, FL_FIRST, 10'h3FF, 19, 0, 0, 1, ST_FRAGMENT));
		plan.push_back(mk_row(RK_READ, 2'd0, FL_INTER, 10'h000, 0, 0, 12'd0, 1, ST_READ));
		plan.push_back(mk_row(RK_READ, 2'd0, FL_INTER, 10'h000, 0, 0, 12'd18, 1, ST_READ));
		plan.push_back(mk_row(RK_PACKET, 2'd0, FL_INTER, 10'h155, 20, 0, 0, 1, ST_IGNORED));
		plan.push_back(mk_row(RK_PACKET, 2'd1, FL_INTER, 10'h2AA, 30, 1, 0, 1, ST_CRC_FAIL));
		plan.push_back(mk_row(RK_PACKET, 2'd3, FL_INTER, 10'h001, 91, 0, 0, 1, ST_FRAGMENT));
		plan.push_back(mk_row(RK_PACKET, 2'd1, FL_LAST, 10'h200, 43, 0, 0, 1, ST_DONE));
		plan.push_back(mk_row(RK_READ, 2'd0, FL_INTER, 10'h000, 0, 0, 12'd152, 1, ST_READ));
		plan.push_back(mk_row(RK_PACKET, 2'd0, FL_LAST, 10'h0F0, 5, 0, 0, 1, ST_IGNORED));
		plan.push_back(mk_row(RK_PACKET, 2'd0, FL_INTER, 10'h00F, 5, 0, 0, 1, ST_IGNORED));
		plan.push_back(mk_row(RK_PACKET, 2'd2, FL_SINGLE, 10'h123, 10, 0, 0, 1, ST_IGNORED));
		plan.push_back(mk_row(RK_CUT, 2'd2, FL_FIRST, 10'h321, 10, 0, 0, 0, ST_BUSY));
		plan.push_back(mk_row(RK_PACKET, 2'd2, FL_FIRST, 10'h0FF, 67, 0, 0, 1, ST_FRAGMENT));
		plan.push_back(mk_row(RK_PACKET, 2'd2, FL_INTER, 10'h300, 127, 0, 0, 1, ST_IGNORED));
		plan.push_back(mk_row(RK_PACKET, 2'd0, FL_FIRST, 10'h0AA, 0, 1, 0, 1, ST_CRC_FAIL));
		plan.push_back(mk_row(RK_PACKET, 2'd3, FL_FIRST, 10'h3C3, 91, 0, 0, 1, ST_FRAGMENT));
		plan.push_back(mk_row(RK_FILL, 2'd3, FL_INTER, 10'h000, 91, 0, 0, 0, ST_BUSY));
		plan.push_back(mk_row(RK_TOPUP, 2'd3, FL_INTER, 10'h2C2, 0, 0, 0, 1, ST_FRAGMENT));
		plan.push_back(mk_row(RK_READ, 2'd0, FL_INTER, 10'h000, 0, 0, 12'd4095, 1, ST_READ));
		plan.push_back(mk_row(RK_READ, 2'd0, FL_INTER, 10'h000, 0, 0, 12'd0, 1, ST_READ));
		plan.push_back(mk_row(RK_PACKET, 2'd0, FL_INTER, 10'h111, 1, 0, 0, 1, ST_OVERFLOW));
		plan.push_back(mk_row(RK_PACKET, 2'd0, FL_LAST, 10'h222, 3, 0, 0, 1, ST_IGNORED));
		plan.push_back(mk_row(RK_READ, 2'd0, FL_INTER, 10'h000, 0, 0, 12'd4095, 1, ST_READ));

		for (k = 0; k < plan.size(); k++) begin
			unique case (plan[k].kind)
				RK_PACKET: begin
					send_packet(plan[k].size, plan[k].flag, plan[k].addr, plan[k].ulen,
						plan[k].bad, 0, plan[k].typed, plan[k].want, 1'b0);
				end
				RK_READ: begin
					send_read(plan[k].idx, plan[k].typed);
				end
				RK_CUT: begin
					send_packet(plan[k].size, plan[k].flag, plan[k].addr, 60, 1'b0,
						plan[k].ulen, 1'b0, ST_BUSY, 1'b0);
				end
				RK_FILL: begin
					while (p_count + plan[k].ulen <= GB) begin
						send_packet(plan[k].size, plan[k].flag, 10'($urandom), plan[k].ulen,
							1'b0, 0, 1'b0, ST_BUSY, 1'b0);
					end
				end
				default: begin
					if (GB - p_count > 0) begin
						send_packet(plan[k].size, plan[k].flag, plan[k].addr, GB - p_count,
							1'b0, 0, plan[k].typed, plan[k].want, 1'b0);
					end
				end
			endcase
		end

		rand_items0 = items_sent;
		rand_pkts0 = pkts_done;
		while (items_sent - rand_items0 < RAND_ITEMS || pkts_done - rand_pkts0 < RAND_PKTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				rand_packet(FL_FIRST);
				n = $urandom_range(0, 3);
				repeat (n) rand_packet(FL_INTER);
				rand_packet(FL_LAST);
			end else if (pick < 85) begin
				rand_packet(2'($urandom));
			end else if (pick < 93) begin
				n = $urandom_range(1, 4);
				repeat (n) send_read(12'($urandom_range(0, mem_hi - 1)), 1'b0);
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					offer_item('{func: 1'b0, data_byte: 8'($urandom),
						frame_start: 1'($urandom), read_index: 12'($urandom)}, 1'b0, ST_BUSY);
				end
				need_resync = 1'b1;
			end
		end
		req_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Sent %0d items: %0d packets finished, %0d groups done, %0d overflows, %0d reads.",
			items_sent, pkts_done, groups_done, overflows, reads_done);
		$display("Checked %0d results with %0d mismatches.", results_checked, errors);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
